[design/lcdcs_pkg.sv]
// Shared types, command codes and byte constants for the LCD character stream controller.
// No dependencies; the decoder and the controller refer to this package by scoped names.
`default_nettype none

package lcdcs_pkg;

   // Width of the buffer read and write positions.
   localparam int unsigned POS_W = 6;

   // Most bytes that one transaction ever sends (init sends six).
   localparam int unsigned SEQ_BYTES = 6;

   // Input commands.
   localparam logic [2:0] CMD_PUSH   = 3'd0;
   localparam logic [2:0] CMD_UPDATE = 3'd1;
   localparam logic [2:0] CMD_CLEAR  = 3'd2;
   localparam logic [2:0] CMD_FWD    = 3'd3;
   localparam logic [2:0] CMD_BACK   = 3'd4;
   localparam logic [2:0] CMD_ON     = 3'd5;
   localparam logic [2:0] CMD_OFF    = 3'd6;
   localparam logic [2:0] CMD_INIT   = 3'd7;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FUNC_SET = 2'd0;
   localparam logic [1:0] CSR_DISP_CTL = 2'd1;
   localparam logic [1:0] CSR_LINE2    = 2'd2;

   // Control characters found in the text buffer.
   localparam logic [7:0] CH_FORM_FEED = 8'h0C;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_GT        = 8'h3E;
   localparam logic [7:0] CH_LT        = 8'h3C;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;

   // LCD instruction bytes and glyphs.
   localparam logic [7:0] LCD_CLEAR       = 8'h01;
   localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] LCD_SET_DDRAM   = 8'h80;
   localparam logic [7:0] LCD_ARROW_COL   = 8'h8F;
   localparam logic [7:0] LCD_FUNC_SET    = 8'h20;
   localparam logic [7:0] LCD_DISP_CTL    = 8'h08;
   localparam logic [7:0] LCD_WAKE_A      = 8'h33;
   localparam logic [7:0] LCD_WAKE_B      = 8'h32;
   localparam logic [7:0] GLYPH_FWD       = 8'h7E;
   localparam logic [7:0] GLYPH_BACK      = 8'h7F;
   localparam logic [7:0] MODE_DISPLAY_ON = 8'h04;
   localparam logic [7:0] MODE_CURSOR     = 8'h02;
   localparam logic [7:0] MODE_BLINK      = 8'h01;

   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   // A list of bytes to send, two nibbles each. A count of zero stands for
   // a single result that drives nothing onto the bus.
   typedef struct packed {
      logic [SEQ_BYTES-1:0][7:0] bytes;
      logic [SEQ_BYTES-1:0]      rs;
      logic [2:0]                nbytes;
   } plan_type;

   // What the character decoder hands back to the controller.
   typedef struct packed {
      plan_type   plan;
      logic [7:0] mode;
   } decode_type;

   function automatic plan_type idle_plan();
      plan_type p;
      p = '0;
      return p;
   endfunction

   function automatic plan_type byte_plan(input logic rs, input logic [7:0] b);
      plan_type p;
      p          = '0;
      p.bytes[0] = b;
      p.rs[0]    = rs;
      p.nbytes   = 3'd1;
      return p;
   endfunction

   function automatic plan_type arrow_plan(input logic [7:0] glyph);
      plan_type p;
      p          = '0;
      p.bytes[0] = LCD_ARROW_COL;
      p.rs[0]    = RS_INSTR;
      p.bytes[1] = glyph;
      p.rs[1]    = RS_DATA;
      p.nbytes   = 3'd2;
      return p;
   endfunction

   function automatic plan_type init_plan(input logic [7:0] func_bits,
                                          input logic [7:0] mode);
      plan_type p;
      p          = '0;
      p.bytes[0] = LCD_WAKE_A;
      p.bytes[1] = LCD_WAKE_B;
      p.bytes[2] = LCD_FUNC_SET | func_bits;
      p.bytes[3] = mode;
      p.bytes[4] = LCD_CLEAR;
      p.bytes[5] = LCD_ENTRY_MODE;
      p.nbytes   = 3'd6;
      return p;
   endfunction

endpackage

`default_nettype wire

[design/lcdcs_ifs.sv]
// Handshake channel interfaces for the LCD character stream controller:
// request, response and configuration write. No dependencies.
`default_nettype none

interface lcdcs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] character;

   modport source (output valid, command, character, input ready);
   modport sink   (input valid, command, character, output ready);
endinterface

interface lcdcs_rsp_if;
   logic       valid;
   logic       ready;
   logic       transfer;
   logic       register_select;
   logic [3:0] nibble;
   logic       last;
   logic       all_shown;
   logic       char_dropped;

   modport source (output valid, transfer, register_select, nibble, last, all_shown,
                   char_dropped, input ready);
   modport sink   (input valid, transfer, register_select, nibble, last, all_shown,
                   char_dropped, output ready);
endinterface

interface lcdcs_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/lcdcs_char_decode.sv]
// Decodes one buffered character into the bytes to send and the new display mode.
// Depends on lcdcs_pkg.
`default_nettype none

module lcdcs_char_decode (
   input  wire logic [7:0]           character,
   input  wire logic [7:0]           mode,
   input  wire logic [6:0]           line2_addr,
   output lcdcs_pkg::decode_type     result
);

   always_comb begin
      result.mode = mode;
      case (character)
         lcdcs_pkg::CH_FORM_FEED: begin
            result.plan = lcdcs_pkg::byte_plan(lcdcs_pkg::RS_INSTR, lcdcs_pkg::LCD_CLEAR);
         end
         lcdcs_pkg::CH_RETURN: begin
            result.plan = lcdcs_pkg::byte_plan(lcdcs_pkg::RS_INSTR,
                                               lcdcs_pkg::LCD_SET_DDRAM);
         end
         lcdcs_pkg::CH_NEWLINE: begin
            result.plan = lcdcs_pkg::byte_plan(lcdcs_pkg::RS_INSTR,
                                               lcdcs_pkg::LCD_SET_DDRAM | {1'b0, line2_addr});
         end
         lcdcs_pkg::CH_GT: begin
            result.plan = lcdcs_pkg::arrow_plan(lcdcs_pkg::GLYPH_FWD);
         end
         lcdcs_pkg::CH_LT: begin
            result.plan = lcdcs_pkg::arrow_plan(lcdcs_pkg::GLYPH_BACK);
         end
         lcdcs_pkg::CH_LBRACE: begin
            result.mode = mode | lcdcs_pkg::MODE_CURSOR;
            result.plan = lcdcs_pkg::byte_plan(lcdcs_pkg::RS_INSTR, result.mode);
         end
         lcdcs_pkg::CH_RBRACE: begin
            result.mode = mode & ~lcdcs_pkg::MODE_CURSOR;
            result.plan = lcdcs_pkg::byte_plan(lcdcs_pkg::RS_INSTR, result.mode);
         end
         lcdcs_pkg::CH_LBRACKET: begin
            result.mode = mode | lcdcs_pkg::MODE_BLINK;
            result.plan = lcdcs_pkg::byte_plan(lcdcs_pkg::RS_INSTR, result.mode);
         end
         lcdcs_pkg::CH_RBRACKET: begin
            result.mode = mode & ~lcdcs_pkg::MODE_BLINK;
            result.plan = lcdcs_pkg::byte_plan(lcdcs_pkg::RS_INSTR, result.mode);
         end
         default: begin
            // Any other character is printed as it stands.
            result.plan = lcdcs_pkg::byte_plan(lcdcs_pkg::RS_DATA, character);
         end
      endcase
   end

endmodule

`default_nettype wire

[design/lcd_char_stream_controller.sv]
// The first response leaves through the EMIT state and the response output register; an update
// that reads the text buffer first waits in READ for the registered buffer read. A request
// yields 1 to 12 responses, one per cycle without stall. A new request is taken only in IDLE,
// once the last response of the previous one has entered the output register.
// Reset (synchronous) clears positions, arrow flags and display mode and restores the config
// registers to their defaults; the text buffer is not cleared and holds nothing valid.
`default_nettype none

module lcd_char_stream_controller #(
   parameter int unsigned BUFFER_DEPTH = 40
) (
   input wire logic         clock,
   input wire logic         reset,
   lcdcs_req_if.sink        req,
   lcdcs_rsp_if.source      rsp,
   lcdcs_csr_if.sink        csr
);

   // The positions are six bits wide; a depth of one still needs a one-bit address.
   localparam int unsigned ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [lcdcs_pkg::POS_W-1:0] DEPTH_POS = lcdcs_pkg::POS_W'(BUFFER_DEPTH);
   localparam logic [lcdcs_pkg::POS_W-1:0] POS_ONE   = lcdcs_pkg::POS_W'(1);

   // Sequencer states. READ waits for the registered text buffer read.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [lcdcs_pkg::POS_W-1:0]   rd_pos_ff, rd_pos_in;
   logic [lcdcs_pkg::POS_W-1:0]   wr_pos_ff, wr_pos_in;
   logic [7:0]                    mode_ff, mode_in;
   logic                          fwd_pend_ff, fwd_pend_in;
   logic                          back_pend_ff, back_pend_in;
   logic [7:0]                    func_bits_ff, func_bits_in;
   logic [2:0]                    disp_bits_ff, disp_bits_in;
   logic [6:0]                    line2_ff, line2_in;
   lcdcs_pkg::plan_type           plan_ff, plan_in;
   logic [3:0]                    nib_idx_ff, nib_idx_in;
   logic                          dropped_ff, dropped_in;

   // Response output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_transfer_ff, rsp_transfer_in;
   logic                          rsp_rs_ff, rsp_rs_in;
   logic [3:0]                    rsp_nibble_ff, rsp_nibble_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_shown_ff, rsp_shown_in;
   logic                          rsp_dropped_ff, rsp_dropped_in;

   // Text buffer: one write port for pushes, one registered read port for updates.
   logic [7:0]                    text_mem [BUFFER_DEPTH];
   logic [7:0]                    rd_data_ff;
   logic                          mem_we;
   logic                          mem_re;

   lcdcs_pkg::decode_type         dec;

   logic                          req_fire;
   logic                          slot_free;
   logic                          plan_idle;
   logic [2:0]                    byte_sel;
   logic [7:0]                    cur_byte;
   logic                          at_last;

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;

   // The output register can take a new nibble when it is empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp.ready;

   assign plan_idle = (plan_ff.nbytes == 3'd0);
   assign byte_sel  = nib_idx_ff[3:1];
   assign cur_byte  = plan_ff.bytes[byte_sel];
   assign at_last   = plan_idle || ((nib_idx_ff + 4'd1) == {plan_ff.nbytes, 1'b0});

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.transfer        = rsp_transfer_ff;
   assign rsp.register_select = rsp_rs_ff;
   assign rsp.nibble          = rsp_nibble_ff;
   assign rsp.last            = rsp_last_ff;
   assign rsp.all_shown       = rsp_shown_ff;
   assign rsp.char_dropped    = rsp_dropped_ff;

   lcdcs_char_decode u_decode (
      .character  (rd_data_ff),
      .mode       (mode_ff),
      .line2_addr (line2_ff),
      .result     (dec)
   );

   always_comb begin
      state_in     = state_ff;
      rd_pos_in    = rd_pos_ff;
      wr_pos_in    = wr_pos_ff;
      mode_in      = mode_ff;
      fwd_pend_in  = fwd_pend_ff;
      back_pend_in = back_pend_ff;
      func_bits_in = func_bits_ff;
      disp_bits_in = disp_bits_ff;
      line2_in     = line2_ff;
      plan_in      = plan_ff;
      nib_idx_in   = nib_idx_ff;
      dropped_in   = dropped_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;

      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_transfer_in = rsp_transfer_ff;
      rsp_rs_in       = rsp_rs_ff;
      rsp_nibble_in   = rsp_nibble_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_shown_in    = rsp_shown_ff;
      rsp_dropped_in  = rsp_dropped_ff;

      // Configuration writes are taken in any cycle; an unknown index is ignored.
      if (csr.valid) begin
         case (csr.index)
            lcdcs_pkg::CSR_FUNC_SET: func_bits_in = csr.data;
            lcdcs_pkg::CSR_DISP_CTL: disp_bits_in = csr.data[2:0];
            lcdcs_pkg::CSR_LINE2:    line2_in     = csr.data[6:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // All state changes of the transaction settle here or in READ, so the
               // all-shown flag is stable for every response that follows.
               state_in   = ST_EMIT;
               nib_idx_in = 4'd0;
               dropped_in = 1'b0;
               plan_in    = lcdcs_pkg::idle_plan();
               case (req.command)
                  lcdcs_pkg::CMD_PUSH: begin
                     if (wr_pos_ff < DEPTH_POS) begin
                        mem_we    = 1'b1;
                        wr_pos_in = wr_pos_ff + POS_ONE;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  lcdcs_pkg::CMD_UPDATE: begin
                     // A pending arrow takes precedence over buffered text.
                     if (fwd_pend_ff) begin
                        plan_in     = lcdcs_pkg::arrow_plan(lcdcs_pkg::GLYPH_FWD);
                        fwd_pend_in = 1'b0;
                     end else if (back_pend_ff) begin
                        plan_in      = lcdcs_pkg::arrow_plan(lcdcs_pkg::GLYPH_BACK);
                        back_pend_in = 1'b0;
                     end else if (rd_pos_ff < wr_pos_ff) begin
                        mem_re   = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        // Nothing left to show: rewind the buffer.
                        rd_pos_in = '0;
                        wr_pos_in = '0;
                     end
                  end
                  lcdcs_pkg::CMD_CLEAR: begin
                     rd_pos_in = '0;
                     wr_pos_in = '0;
                  end
                  lcdcs_pkg::CMD_FWD:  fwd_pend_in  = 1'b1;
                  lcdcs_pkg::CMD_BACK: back_pend_in = 1'b1;
                  lcdcs_pkg::CMD_ON: begin
                     mode_in = mode_ff | lcdcs_pkg::MODE_DISPLAY_ON;
                     plan_in = lcdcs_pkg::byte_plan(lcdcs_pkg::RS_INSTR,
                                                    mode_ff | lcdcs_pkg::MODE_DISPLAY_ON);
                  end
                  lcdcs_pkg::CMD_OFF: begin
                     mode_in = mode_ff & ~lcdcs_pkg::MODE_DISPLAY_ON;
                     plan_in = lcdcs_pkg::byte_plan(lcdcs_pkg::RS_INSTR,
                                                    mode_ff & ~lcdcs_pkg::MODE_DISPLAY_ON);
                  end
                  default: begin
                     // Init: wake-up nibbles, then function set, display control,
                     // clear and entry mode.
                     mode_in = lcdcs_pkg::LCD_DISP_CTL | {5'd0, disp_bits_ff};
                     plan_in = lcdcs_pkg::init_plan(func_bits_ff,
                                  lcdcs_pkg::LCD_DISP_CTL | {5'd0, disp_bits_ff});
                  end
               endcase
            end
         end
         ST_READ: begin
            // The buffered character is now in the read register.
            plan_in   = dec.plan;
            mode_in   = dec.mode;
            rd_pos_in = rd_pos_ff + POS_ONE;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_transfer_in = !plan_idle;
               rsp_rs_in       = plan_idle ? lcdcs_pkg::RS_INSTR : plan_ff.rs[byte_sel];
               rsp_nibble_in   = plan_idle ? 4'd0 :
                                 (nib_idx_ff[0] ? cur_byte[3:0] : cur_byte[7:4]);
               rsp_last_in     = at_last;
               rsp_shown_in    = (rd_pos_ff == '0) && (wr_pos_ff == '0);
               rsp_dropped_in  = dropped_ff;
               nib_idx_in      = nib_idx_ff + 4'd1;
               if (at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pos_ff    <= '0;
         wr_pos_ff    <= '0;
         mode_ff      <= '0;
         fwd_pend_ff  <= 1'b0;
         back_pend_ff <= 1'b0;
         func_bits_ff <= 8'd8;
         disp_bits_ff <= 3'd4;
         line2_ff     <= 7'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pos_ff    <= rd_pos_in;
         wr_pos_ff    <= wr_pos_in;
         mode_ff      <= mode_in;
         fwd_pend_ff  <= fwd_pend_in;
         back_pend_ff <= back_pend_in;
         func_bits_ff <= func_bits_in;
         disp_bits_ff <= disp_bits_in;
         line2_ff     <= line2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff         <= plan_in;
      nib_idx_ff      <= nib_idx_in;
      dropped_ff      <= dropped_in;
      rsp_transfer_ff <= rsp_transfer_in;
      rsp_rs_ff       <= rsp_rs_in;
      rsp_nibble_ff   <= rsp_nibble_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_shown_ff    <= rsp_shown_in;
      rsp_dropped_ff  <= rsp_dropped_in;
   end

   // Text buffer. Reads and writes never meet in one transaction, so no forwarding.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_mem[wr_pos_ff[ADDR_W-1:0]] <= req.character;
      end
      if (mem_re) begin
         rd_data_ff <= text_mem[rd_pos_ff[ADDR_W-1:0]];
      end
   end

   // The write position never runs past the buffer.
   assert property (@(posedge clock) disable iff (reset) wr_pos_ff <= DEPTH_POS)
      else $error("write position beyond buffer depth");

   // Text is never read ahead of what was written.
   assert property (@(posedge clock) disable iff (reset) rd_pos_ff <= wr_pos_ff)
      else $error("read position ahead of write position");

   // A buffer read is only issued for an entry below the write position.
   assert property (@(posedge clock) disable iff (reset)
      mem_re |-> (rd_pos_ff < wr_pos_ff) && (state_ff == ST_IDLE))
      else $error("text buffer read of an unwritten entry");

   // Init leaves the display-control base bit set in the mode.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req.command == lcdcs_pkg::CMD_INIT)) |=> mode_ff[3])
      else $error("init did not set the display mode");

   // A response without a bus transfer is always the only one of its transaction.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_transfer_ff) |-> rsp_last_ff)
      else $error("idle response not marked last");

endmodule

`default_nettype wire

[tb/tb_lcd_char_stream_controller.sv]
// Self-checking testbench for lcd_char_stream_controller: drives character, update, arrow,
// display and init requests plus configuration writes, and checks every LCD bus nibble.
// Depends on lcdcs_pkg and the channel interfaces in lcdcs_ifs.sv.
`default_nettype none

module tb_lcd_char_stream_controller;

   localparam int unsigned BUFFER_DEPTH = 40;
   localparam int MAX_CYCLES    = 1_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int REPORT_LIMIT  = 10;
   localparam int MAX_NIBBLES   = 12;

   // One response transaction as it appears on the response channel.
   typedef struct packed {
      logic       transfer;
      logic       register_select;
      logic [3:0] nibble;
      logic       last;
      logic       all_shown;
      logic       char_dropped;
   } bus_nibble_type;

   // The scoreboard keeps its own copy of the controller state. Each accepted request is
   // turned into the list of bus nibbles it must produce, and responses are matched in order.
   class bus_nibble_scoreboard;
      bus_nibble_type expected_nibbles[$];
      bus_nibble_type step_nibbles[$];
      logic [7:0]  text_buf [64];
      logic [5:0]  rd_pos;
      logic [5:0]  wr_pos;
      logic [7:0]  mode;
      bit          fwd_pending;
      bit          back_pending;
      logic [7:0]  func_bits;
      logic [2:0]  ctl_bits;
      logic [6:0]  line2_addr;
      int          failures;

      function new();
         foreach (text_buf[i]) text_buf[i] = '0;
         rd_pos       = '0;
         wr_pos       = '0;
         mode         = '0;
         fwd_pending  = 1'b0;
         back_pending = 1'b0;
         func_bits    = 8'd8;
         ctl_bits     = 3'd4;
         line2_addr   = 7'd64;
         failures     = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [7:0] value);
         case (idx)
            lcdcs_pkg::CSR_FUNC_SET: func_bits  = value;
            lcdcs_pkg::CSR_DISP_CTL: ctl_bits   = value[2:0];
            lcdcs_pkg::CSR_LINE2:    line2_addr = value[6:0];
            default: ;
         endcase
      endfunction

      function void emit_nibble(logic rs, logic [3:0] nib);
         bus_nibble_type n;
         n = '0;
         n.transfer        = 1'b1;
         n.register_select = rs;
         n.nibble          = nib;
         if (step_nibbles.size() < MAX_NIBBLES) step_nibbles.push_back(n);
      endfunction

      function void emit_byte(logic rs, logic [7:0] b);
         emit_nibble(rs, b[7:4]);
         emit_nibble(rs, b[3:0]);
      endfunction

      function void emit_arrow(logic [7:0] glyph);
         emit_byte(lcdcs_pkg::RS_INSTR, lcdcs_pkg::LCD_ARROW_COL);
         emit_byte(lcdcs_pkg::RS_DATA, glyph);
      endfunction

      // Decodes the next buffered character, or sends a pending arrow first, or rewinds an empty buffer.
      function void predict_update();
         logic [7:0] c;
         if (fwd_pending) begin
            emit_arrow(lcdcs_pkg::GLYPH_FWD);
            fwd_pending = 1'b0;
         end else if (back_pending) begin
            emit_arrow(lcdcs_pkg::GLYPH_BACK);
            back_pending = 1'b0;
         end else if (rd_pos < wr_pos) begin
            c = text_buf[rd_pos];
            case (c)
               lcdcs_pkg::CH_FORM_FEED:
                  emit_byte(lcdcs_pkg::RS_INSTR, lcdcs_pkg::LCD_CLEAR);
               lcdcs_pkg::CH_RETURN:
                  emit_byte(lcdcs_pkg::RS_INSTR, lcdcs_pkg::LCD_SET_DDRAM);
               lcdcs_pkg::CH_NEWLINE:
                  emit_byte(lcdcs_pkg::RS_INSTR, lcdcs_pkg::LCD_SET_DDRAM | {1'b0, line2_addr});
               lcdcs_pkg::CH_GT:        emit_arrow(lcdcs_pkg::GLYPH_FWD);
               lcdcs_pkg::CH_LT:        emit_arrow(lcdcs_pkg::GLYPH_BACK);
               lcdcs_pkg::CH_LBRACE: begin
                  mode = mode | lcdcs_pkg::MODE_CURSOR;
                  emit_byte(lcdcs_pkg::RS_INSTR, mode);
               end
               lcdcs_pkg::CH_RBRACE: begin
                  mode = mode & ~lcdcs_pkg::MODE_CURSOR;
                  emit_byte(lcdcs_pkg::RS_INSTR, mode);
               end
               lcdcs_pkg::CH_LBRACKET: begin
                  mode = mode | lcdcs_pkg::MODE_BLINK;
                  emit_byte(lcdcs_pkg::RS_INSTR, mode);
               end
               lcdcs_pkg::CH_RBRACKET: begin
                  mode = mode & ~lcdcs_pkg::MODE_BLINK;
                  emit_byte(lcdcs_pkg::RS_INSTR, mode);
               end
               default: emit_byte(lcdcs_pkg::RS_DATA, c);
            endcase
            rd_pos = rd_pos + 6'd1;
         end else begin
            // Nothing left to show: both positions fold back to the start.
            rd_pos = '0;
            wr_pos = '0;
            step_nibbles.push_back('0);
         end
      endfunction

      // Called once per accepted request transaction.
      function void note_request(logic [2:0] cmd, logic [7:0] ch);
         bit dropped;
         bit shown;
         dropped = 1'b0;
         step_nibbles.delete();
         case (cmd)
            lcdcs_pkg::CMD_PUSH: begin
               if (wr_pos < BUFFER_DEPTH) begin
                  text_buf[wr_pos] = ch;
                  wr_pos = wr_pos + 6'd1;
               end else begin
                  dropped = 1'b1;
               end
               step_nibbles.push_back('0);
            end
            lcdcs_pkg::CMD_UPDATE: predict_update();
            lcdcs_pkg::CMD_CLEAR: begin
               rd_pos = '0;
               wr_pos = '0;
               step_nibbles.push_back('0);
            end
            lcdcs_pkg::CMD_FWD: begin
               fwd_pending = 1'b1;
               step_nibbles.push_back('0);
            end
            lcdcs_pkg::CMD_BACK: begin
               back_pending = 1'b1;
               step_nibbles.push_back('0);
            end
            lcdcs_pkg::CMD_ON: begin
               mode = mode | lcdcs_pkg::MODE_DISPLAY_ON;
               emit_byte(lcdcs_pkg::RS_INSTR, mode);
            end
            lcdcs_pkg::CMD_OFF: begin
               mode = mode & ~lcdcs_pkg::MODE_DISPLAY_ON;
               emit_byte(lcdcs_pkg::RS_INSTR, mode);
            end
            default: begin
               // Wake-up nibbles 3, 3, 3, 2 followed by the set-up bytes.
               emit_byte(lcdcs_pkg::RS_INSTR, lcdcs_pkg::LCD_WAKE_A);
               emit_byte(lcdcs_pkg::RS_INSTR, lcdcs_pkg::LCD_WAKE_B);
               emit_byte(lcdcs_pkg::RS_INSTR, lcdcs_pkg::LCD_FUNC_SET | func_bits);
               mode = lcdcs_pkg::LCD_DISP_CTL | {5'b0, ctl_bits};
               emit_byte(lcdcs_pkg::RS_INSTR, mode);
               emit_byte(lcdcs_pkg::RS_INSTR, lcdcs_pkg::LCD_CLEAR);
               emit_byte(lcdcs_pkg::RS_INSTR, lcdcs_pkg::LCD_ENTRY_MODE);
            end
         endcase
         shown = (rd_pos == 0) && (wr_pos == 0);
         foreach (step_nibbles[k]) begin
            step_nibbles[k].all_shown    = shown;
            step_nibbles[k].char_dropped = dropped;
         end
         step_nibbles[step_nibbles.size() - 1].last = 1'b1;
         foreach (step_nibbles[k]) expected_nibbles.push_back(step_nibbles[k]);
      endfunction

      function string describe(bus_nibble_type n);
         return $sformatf("xfer=%0d rs=%0d nib=%h last=%0d shown=%0d drop=%0d", n.transfer,
                          n.register_select, n.nibble, n.last, n.all_shown, n.char_dropped);
      endfunction

      // Called once per accepted response transaction.
      function void check_bus_nibble(bus_nibble_type got);
         bus_nibble_type want;
         if (expected_nibbles.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("[%0t] unexpected bus nibble: %s", $time, describe(got));
            return;
         end
         want = expected_nibbles.pop_front();
         if (got.transfer !== want.transfer || got.register_select !== want.register_select ||
             got.nibble !== want.nibble || got.last !== want.last ||
             got.all_shown !== want.all_shown || got.char_dropped !== want.char_dropped) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("[%0t] bus nibble mismatch: expected %s, got %s", $time,
                        describe(want), describe(got));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lcdcs_req_if req_ch();
   lcdcs_rsp_if rsp_ch();
   lcdcs_csr_if csr_ch();

   bus_nibble_scoreboard sb;
   int cycle_count = 0;
   int items_sent;
   bit steady_sender;

   // Characters that the controller decodes into something other than plain data.
   logic [7:0] control_chars [9] = '{lcdcs_pkg::CH_FORM_FEED, lcdcs_pkg::CH_RETURN,
                                     lcdcs_pkg::CH_NEWLINE, lcdcs_pkg::CH_GT,
                                     lcdcs_pkg::CH_LT, lcdcs_pkg::CH_LBRACE,
                                     lcdcs_pkg::CH_RBRACE, lcdcs_pkg::CH_LBRACKET,
                                     lcdcs_pkg::CH_RBRACKET};

   lcd_char_stream_controller #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   always #5 clock = ~clock;

   // The run is bounded by a cycle counter so that a hung handshake cannot stall forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Every response transaction is checked at the rising edge where it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_bus_nibble({rsp_ch.transfer, rsp_ch.register_select, rsp_ch.nibble,
                              rsp_ch.last, rsp_ch.all_shown, rsp_ch.char_dropped});
   end

   // The response side stalls at random: mostly short stalls, now and then a long one,
   // and some stretches where ready simply stays high.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         if ($urandom_range(0, 9) < 3) begin
            @(negedge clock) rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(10, 50)) @(negedge clock);
         end else begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
            @(negedge clock) rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
            @(negedge clock) rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end
      end
   end

   function automatic int sender_gap();
      int r;
      if (steady_sender) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   // Picks a byte with a strong bias toward the characters that have a meaning of their own.
   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 9) < 4) return control_chars[$urandom_range(0, 8)];
      return 8'($urandom_range(0, 255));
   endfunction

   // Offers one request transaction and waits for it to be accepted. Valid stays high
   // into the next call when no gap follows, so it is never dropped and raised in one step.
   task automatic send_request(input logic [2:0] cmd, input logic [7:0] ch);
      int gap;
      gap = sender_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= cmd;
      req_ch.character <= ch;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(cmd, ch);
      items_sent++;
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_register(idx, value);
      @(negedge clock) csr_ch.valid <= 1'b0;
   endtask

   // Stops sending, waits for every expected nibble, then lets the block settle.
   task automatic drain_block();
      @(negedge clock) req_ch.valid <= 1'b0;
      while (sb.expected_nibbles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random traffic made mostly of well-formed sequences: text pushed and then shown,
   // arrow requests followed by updates, and display commands, with some noise mixed in.
   task automatic run_random_traffic(input int count);
      int stop_at;
      int kind;
      int n;
      int k;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         steady_sender = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            // Occasionally a long burst can run past the end of the text buffer.
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(36, 46) : $urandom_range(1, 10);
            if ($urandom_range(0, 2) == 0) begin
               for (k = 0; k < 2 * n; k++) begin
                  if ($urandom_range(0, 1)) send_request(lcdcs_pkg::CMD_PUSH, pick_char());
                  else send_request(lcdcs_pkg::CMD_UPDATE, 8'($urandom_range(0, 255)));
               end
            end else begin
               for (k = 0; k < n; k++) send_request(lcdcs_pkg::CMD_PUSH, pick_char());
               for (k = 0; k < n + $urandom_range(0, 2); k++) begin
                  // A clear now and then cuts a sequence short.
                  if ($urandom_range(0, 19) == 0)
                     send_request(lcdcs_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
                  else
                     send_request(lcdcs_pkg::CMD_UPDATE, 8'($urandom_range(0, 255)));
               end
            end
         end else if (kind < 70) begin
            case ($urandom_range(0, 2))
               0: send_request(lcdcs_pkg::CMD_FWD, 8'($urandom_range(0, 255)));
               1: send_request(lcdcs_pkg::CMD_BACK, 8'($urandom_range(0, 255)));
               default: begin
                  send_request(lcdcs_pkg::CMD_BACK, 8'($urandom_range(0, 255)));
                  send_request(lcdcs_pkg::CMD_FWD, 8'($urandom_range(0, 255)));
               end
            endcase
            repeat ($urandom_range(1, 3))
               send_request(lcdcs_pkg::CMD_UPDATE, 8'($urandom_range(0, 255)));
         end else if (kind < 85) begin
            case ($urandom_range(0, 2))
               0: send_request(lcdcs_pkg::CMD_ON, 8'($urandom_range(0, 255)));
               1: send_request(lcdcs_pkg::CMD_OFF, 8'($urandom_range(0, 255)));
               default: send_request(lcdcs_pkg::CMD_INIT, 8'($urandom_range(0, 255)));
            endcase
         end else begin
            repeat ($urandom_range(1, 4))
               send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
         end
      end
      steady_sender = 1'b0;
   endtask

   initial begin
      int phase;
      logic [7:0] func_value;
      logic [7:0] ctl_value;
      logic [7:0] line2_value;

      clock            = 1'b0;
      reset            = 1'b1;
      items_sent       = 0;
      steady_sender    = 1'b0;
      req_ch.valid     = 1'b0;
      req_ch.command   = lcdcs_pkg::CMD_PUSH;
      req_ch.character = 8'h00;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = lcdcs_pkg::CSR_FUNC_SET;
      csr_ch.data      = 8'h00;
      sb = new();

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed opening with the registers at their reset values. An update on an empty
      // buffer comes first, then the display commands before any init, so the raw mode
      // byte goes out without its display-control bit.
      send_request(lcdcs_pkg::CMD_UPDATE, 8'h00);
      send_request(lcdcs_pkg::CMD_ON, 8'h00);
      send_request(lcdcs_pkg::CMD_OFF, 8'hFF);
      send_request(lcdcs_pkg::CMD_INIT, 8'h00);
      // Both arrows are pending at once; the forward one must win the first update.
      send_request(lcdcs_pkg::CMD_FWD, 8'h00);
      send_request(lcdcs_pkg::CMD_BACK, 8'h00);
      send_request(lcdcs_pkg::CMD_PUSH, lcdcs_pkg::CH_FORM_FEED);
      send_request(lcdcs_pkg::CMD_PUSH, lcdcs_pkg::CH_NEWLINE);
      send_request(lcdcs_pkg::CMD_PUSH, lcdcs_pkg::CH_GT);
      send_request(lcdcs_pkg::CMD_PUSH, lcdcs_pkg::CH_LBRACE);
      send_request(lcdcs_pkg::CMD_PUSH, lcdcs_pkg::CH_RBRACKET);
      send_request(lcdcs_pkg::CMD_PUSH, 8'hFF);
      send_request(lcdcs_pkg::CMD_PUSH, 8'h00);
      // Two arrows, seven characters, and a final update that finds the buffer empty.
      repeat (10) send_request(lcdcs_pkg::CMD_UPDATE, 8'h00);
      send_request(lcdcs_pkg::CMD_CLEAR, 8'h00);

      // Fill the buffer one past its depth so the last push is dropped, then show it all.
      repeat (BUFFER_DEPTH + 1) send_request(lcdcs_pkg::CMD_PUSH, pick_char());
      repeat (BUFFER_DEPTH + 1)
         send_request(lcdcs_pkg::CMD_UPDATE, 8'($urandom_range(0, 255)));

      run_random_traffic(10);

      // Each later phase starts from an idle block with a new register setting: first
      // all registers at their low end, then at their high end, then random values.
      for (phase = 1; phase <= 4; phase++) begin
         drain_block();
         case (phase)
            1: begin
               func_value  = 8'h00;
               ctl_value   = 8'h00;
               line2_value = 8'h00;
            end
            2: begin
               func_value  = 8'hFF;
               ctl_value   = 8'h07;
               line2_value = 8'h7F;
            end
            default: begin
               func_value  = 8'($urandom_range(0, 255));
               ctl_value   = 8'($urandom_range(0, 7));
               line2_value = 8'($urandom_range(0, 127));
            end
         endcase
         write_register(lcdcs_pkg::CSR_FUNC_SET, func_value);
         write_register(lcdcs_pkg::CSR_DISP_CTL, ctl_value);
         write_register(lcdcs_pkg::CSR_LINE2, line2_value);
         // Use the new setting in an init and then in a pushed newline and an update.
         send_request(lcdcs_pkg::CMD_INIT, 8'($urandom_range(0, 255)));
         send_request(lcdcs_pkg::CMD_PUSH, lcdcs_pkg::CH_NEWLINE);
         send_request(lcdcs_pkg::CMD_UPDATE, 8'($urandom_range(0, 255)));
         run_random_traffic(22);
      end

      drain_block();
      if (sb.failures == 0 && sb.expected_nibbles.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
